### hdl/zpg_pkg.sv
package zpg_pkg;

  localparam int MAX_ELEMS = 8;
  localparam int ELEM_BITS = $clog2(MAX_ELEMS);
  localparam int PERM_W    = MAX_ELEMS * ELEM_BITS;
  localparam int LEN_W     = $clog2(MAX_ELEMS + 1);
  localparam int DIG_W     = $clog2(MAX_ELEMS);
  localparam int IDX_W     = $clog2(MAX_ELEMS);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [LEN_W-1:0] MIN_LEN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_ELEMS);

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic {
    REG_PERM_LENGTH = 1'b0,
    REG_NONE        = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [PERM_W-1:0]                  perm;
    logic [MAX_ELEMS-1:1][DIG_W-1:0]    digits;
    logic                               done;
  } state_t;

  typedef struct packed {
    logic [PERM_W-1:0] perm;
    logic [LEN_W-1:0]  suffix_len;
    logic              last;
    logic              overrun;
  } result_t;

endpackage

### hdl/zaks_permutation_generator_unit.sv
// zaks prefix-reversal permutation generator
//
// input channel (in_valid / in_stall): op selects load or advance. a load
// transfer stores start_perm, clears the step counter and returns start_perm.
// an advance transfer reverses the last suffix_len elements and returns the
// new permutation; the final permutation of the n! sequence has last set, and
// an advance after that returns the same permutation with overrun set.
// output channel (out_valid / out_stall): one result per input transfer.
// the result is registered in the output buffer; one item per cycle is
// sustained while the receiver does not stall, the counter increment and
// reversal being combinational ahead of the result register.
// a two-entry output buffer (result register plus skid) lets one more input
// be taken while the receiver stalls; in_stall rises only when both are full.
// apb port: perm_length at address 0, read back on prdata. the user must
// write it only while the block is idle; the block does not enforce it. reset
// sets perm_length to 8, clears permutation, counter, done flag and buffer.
module zaks_permutation_generator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [zpg_pkg::ADDR_W-1:0]  paddr,
  input  logic [zpg_pkg::DATA_W-1:0]  pwdata,
  output logic [zpg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [zpg_pkg::PERM_W-1:0]  start_perm,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [zpg_pkg::PERM_W-1:0]  perm_out,
  output logic [zpg_pkg::LEN_W-1:0]   suffix_len,
  output logic                        last,
  output logic                        overrun
);
  import zpg_pkg::*;

  logic [LEN_W-1:0] perm_length;
  state_t           cur;
  state_t           cur_next;
  result_t          res;
  result_t          out_data;
  logic             in_xfer;
  reg_idx_t         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign prdata  = (reg_idx == REG_PERM_LENGTH) ? DATA_W'(perm_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_length <= LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_PERM_LENGTH) begin
      perm_length <= pwdata[LEN_W-1:0];
    end
  end

  assign in_xfer = in_valid && !in_stall;

  zpg_step u_step (
    .perm_length (perm_length),
    .op          (op),
    .start_perm  (start_perm),
    .cur         (cur),
    .nxt         (cur_next),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (in_xfer) begin
      cur <= cur_next;
    end
  end

  zpg_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_xfer),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign perm_out   = out_data.perm;
  assign suffix_len = out_data.suffix_len;
  assign last       = out_data.last;
  assign overrun    = out_data.overrun;

endmodule

### hdl/zpg_step.sv
module zpg_step (
  input  logic [zpg_pkg::LEN_W-1:0]  perm_length,
  input  logic                       op,
  input  logic [zpg_pkg::PERM_W-1:0] start_perm,
  input  zpg_pkg::state_t            cur,
  output zpg_pkg::state_t            nxt,
  output zpg_pkg::result_t           res
);
  import zpg_pkg::*;

  logic [LEN_W-1:0]                n;
  logic                            at_top;
  logic                            new_top;
  logic                            found;
  logic [LEN_W-1:0]                sel;
  logic [LEN_W-1:0]                s;
  logic [LEN_W-1:0]                lo;
  logic [MAX_ELEMS-1:1][DIG_W-1:0] nd;
  logic [PERM_W-1:0]               np;
  logic [LEN_W:0]                  src;

  always_comb begin
    if (perm_length < MIN_LEN) begin
      n = MIN_LEN;
    end else if (perm_length > LEN_RESET) begin
      n = LEN_RESET;
    end else begin
      n = perm_length;
    end
  end

  // counter top check on current digits
  always_comb begin
    at_top = 1'b1;
    for (int j = 1; j < MAX_ELEMS; j++) begin
      if (LEN_W'(j) < n && cur.digits[j] != DIG_W'(j)) begin
        at_top = 1'b0;
      end
    end
  end

  // factorial-base increment, carry stops at the first digit below its max
  always_comb begin
    nd    = cur.digits;
    found = 1'b0;
    sel   = '0;
    for (int j = 1; j < MAX_ELEMS; j++) begin
      if (LEN_W'(j) < n && !found) begin
        if (cur.digits[j] < DIG_W'(j)) begin
          nd[j] = cur.digits[j] + DIG_W'(1);
          found = 1'b1;
          sel   = LEN_W'(j);
        end else begin
          nd[j] = '0;
        end
      end
    end
    s = sel + LEN_W'(1);
  end

  always_comb begin
    new_top = 1'b1;
    for (int j = 1; j < MAX_ELEMS; j++) begin
      if (LEN_W'(j) < n && nd[j] != DIG_W'(j)) begin
        new_top = 1'b0;
      end
    end
  end

  // reverse positions lo..n-1
  always_comb begin
    lo  = n - s;
    np  = cur.perm;
    src = '0;
    for (int i = 0; i < MAX_ELEMS; i++) begin
      if (LEN_W'(i) >= lo && LEN_W'(i) < n) begin
        src = {1'b0, lo} + {1'b0, n} - (LEN_W + 1)'(1) - (LEN_W + 1)'(i);
        np[i*ELEM_BITS +: ELEM_BITS] =
          cur.perm[src[IDX_W-1:0]*ELEM_BITS +: ELEM_BITS];
      end
    end
  end

  always_comb begin
    nxt = cur;
    res = '0;
    if (op == OP_LOAD) begin
      nxt.perm   = start_perm;
      nxt.digits = '0;
      nxt.done   = 1'b0;
      res.perm   = start_perm;
    end else if (cur.done || at_top) begin
      nxt.done    = 1'b1;
      res.perm    = cur.perm;
      res.overrun = 1'b1;
    end else begin
      nxt.perm       = np;
      nxt.digits     = nd;
      nxt.done       = new_top;
      res.perm       = np;
      res.suffix_len = s;
      res.last       = new_top;
    end
  end

endmodule

### hdl/zpg_out_buf.sv
module zpg_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  zpg_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output zpg_pkg::result_t out_data
);
  import zpg_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_data   <= skid;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid       <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### bench/zaks_permutation_generator_unit_tb.sv
`timescale 1ns / 1ps

module zaks_permutation_generator_unit_tb;
  import zpg_pkg::*;

  localparam logic [PERM_W-1:0] IDENT_PERM = 24'hFAC688;
  localparam logic [ADDR_W-1:0] LEN_ADDR = {REG_PERM_LENGTH, 2'b00};

  typedef struct {
    op_t               op;
    logic [PERM_W-1:0] start_perm;
  } gen_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              op = 1'b0;
  logic [PERM_W-1:0] start_perm = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PERM_W-1:0] perm_out;
  logic [LEN_W-1:0]  suffix_len;
  logic              last;
  logic              overrun;

  gen_item_t gen_pending[$];
  result_t   perm_expected[$];
  gen_item_t drv_item;
  result_t   want;
  int        errors = 0;
  int        issued = 0;
  bit        calm = 1'b0;

  // predictor state
  logic [LEN_W-1:0]  len_model = LEN_RESET;
  logic [PERM_W-1:0] perm_model = '0;
  logic [DIG_W-1:0]  digit_model [MAX_ELEMS];
  bit                done_model = 1'b0;

  zaks_permutation_generator_unit u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .start_perm(start_perm),
    .out_valid(out_valid), .out_stall(out_stall), .perm_out(perm_out),
    .suffix_len(suffix_len), .last(last), .overrun(overrun)
  );

  always #10 clk = ~clk;

  initial begin
    for (int i = 0; i < MAX_ELEMS; i++) digit_model[i] = '0;
  end

  function automatic int eff_length(input logic [LEN_W-1:0] len);
    if (len < MIN_LEN) return 2;
    if (len > MAX_ELEMS) return MAX_ELEMS;
    return int'(len);
  endfunction

  function automatic bit digits_at_top(input int n);
    bit top;
    top = 1'b1;
    for (int j = 1; j < n; j++)
      if (digit_model[j] != j) top = 1'b0;
    return top;
  endfunction

  function automatic result_t zaks_step(input op_t o, input logic [PERM_W-1:0] sp);
    result_t              r;
    int                   n;
    int                   s;
    int                   lo;
    int                   hi;
    bit                   carry;
    logic [ELEM_BITS-1:0] tmp;
    r = '0;
    s = 0;
    n = eff_length(len_model);
    if (o == OP_LOAD) begin
      perm_model = sp;
      for (int j = 0; j < MAX_ELEMS; j++) digit_model[j] = '0;
      done_model = 1'b0;
    end else if (done_model || digits_at_top(n)) begin
      done_model = 1'b1;
      r.overrun = 1'b1;
    end else begin
      // factorial-base increment, the digit that absorbs the carry sets the suffix
      carry = 1'b1;
      for (int j = 1; j < n; j++) begin
        if (carry) begin
          if (digit_model[j] < j) begin
            digit_model[j] = digit_model[j] + 1'b1;
            carry = 1'b0;
            s = j + 1;
          end else begin
            digit_model[j] = '0;
          end
        end
      end
      lo = n - s;
      hi = n - 1;
      while (lo < hi) begin
        tmp = perm_model[ELEM_BITS*lo +: ELEM_BITS];
        perm_model[ELEM_BITS*lo +: ELEM_BITS] = perm_model[ELEM_BITS*hi +: ELEM_BITS];
        perm_model[ELEM_BITS*hi +: ELEM_BITS] = tmp;
        lo++;
        hi--;
      end
      if (digits_at_top(n)) begin
        r.last = 1'b1;
        done_model = 1'b1;
      end
    end
    r.perm = perm_model;
    r.suffix_len = LEN_W'(s);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gen_pending.size() > 0 && (calm || $urandom_range(0, 99) >= 16)) begin
        drv_item = gen_pending.pop_front();
        in_valid <= 1'b1;
        op <= drv_item.op;
        start_perm <= drv_item.start_perm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(0, 99) < 16);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        perm_expected.push_back(zaks_step(op_t'(op), start_perm));
      if (out_valid && !out_stall) begin
        if (perm_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual perm_out %h", $time, perm_out);
          errors++;
        end else begin
          want = perm_expected.pop_front();
          if (perm_out !== want.perm) begin
            $display("%0t: perm_out expected %h actual %h", $time, want.perm, perm_out);
            errors++;
          end
          if (suffix_len !== want.suffix_len) begin
            $display("%0t: suffix_len expected %0d actual %0d", $time, want.suffix_len,
                     suffix_len);
            errors++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last);
            errors++;
          end
          if (overrun !== want.overrun) begin
            $display("%0t: overrun expected %b actual %b", $time, want.overrun, overrun);
            errors++;
          end
        end
      end
    end
  end

  task automatic queue_item(input op_t o, input logic [PERM_W-1:0] sp);
    gen_item_t it;
    it.op = o;
    it.start_perm = sp;
    gen_pending.push_back(it);
    issued++;
  endtask

  task automatic drain();
    do @(negedge clk); while (gen_pending.size() != 0 || in_valid || perm_expected.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_length(input logic [DATA_W-1:0] v);
    drain();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LEN_ADDR;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    len_model = v[LEN_W-1:0];
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[LEN_W-1:0] !== len_model) begin
      $display("%0t: perm_length readback expected %0d actual %0d", $time, len_model,
               prdata[LEN_W-1:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int               n_eff;
    int               adv;
    int               fact;
    int               seqs;
    int               roll;
    int               phase;
    logic [DATA_W-1:0] v;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset length, advance before any load
    queue_item(OP_ADVANCE, PERM_W'($urandom()));
    queue_item(OP_LOAD, 24'hFFFFFF);
    queue_item(OP_ADVANCE, 24'h000000);
    queue_item(OP_LOAD, IDENT_PERM);
    queue_item(OP_ADVANCE, PERM_W'($urandom()));
    queue_item(OP_ADVANCE, PERM_W'($urandom()));

    // shortest sequence, junk in the upper data bits
    set_length(32'hFFFF_FFF2);
    queue_item(OP_LOAD, IDENT_PERM);
    queue_item(OP_ADVANCE, 24'hFFFFFF);
    queue_item(OP_ADVANCE, 24'h000000);

    // full sequence of 3 elements then one past the end
    set_length(32'd3);
    queue_item(OP_LOAD, IDENT_PERM);
    repeat (6) queue_item(OP_ADVANCE, PERM_W'($urandom()));

    set_length(32'd4);
    queue_item(OP_LOAD, PERM_W'($urandom()));
    repeat (5) queue_item(OP_ADVANCE, PERM_W'($urandom()));

    // length below range, shrinks onto a counter already at its top
    set_length(32'd1);
    queue_item(OP_ADVANCE, PERM_W'($urandom()));

    // length above range
    set_length(32'd15);
    queue_item(OP_LOAD, 24'h000000);
    queue_item(OP_ADVANCE, PERM_W'($urandom()));

    phase = 0;
    while (issued < 400) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) v = $urandom_range(0, 1);
      else if (roll < 35) v = 2;
      else if (roll < 60) v = 3;
      else if (roll < 80) v = 4;
      else if (roll < 88) v = 5;
      else if (roll < 94) v = $urandom_range(6, 8);
      else v = $urandom_range(9, 15);
      v[DATA_W-1:LEN_W] = (DATA_W - LEN_W)'($urandom());
      set_length(v);
      calm = (phase == 3);
      n_eff = eff_length(v[LEN_W-1:0]);
      seqs = $urandom_range(1, 2);
      for (int k = 0; k < seqs; k++) begin
        // sometimes carry on from the state left by the previous length
        if (k > 0 || $urandom_range(0, 4) != 0) queue_item(OP_LOAD, PERM_W'($urandom()));
        if (n_eff <= 5) begin
          fact = 1;
          for (int f = 2; f <= n_eff; f++) fact = fact * f;
          adv = fact - 1 + $urandom_range(0, 2);
        end else begin
          adv = $urandom_range(1, 130);
        end
        for (int m = 0; m < adv; m++) begin
          if ($urandom_range(0, 99) < 2) queue_item(OP_LOAD, PERM_W'($urandom()));
          else queue_item(OP_ADVANCE, PERM_W'($urandom()));
        end
      end
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (perm_expected.size() != 0) begin
      $display("%0t: %0d results still expected, actual none", $time, perm_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
